// ----- hw/rtl/hhbp_pkg.sv -----
// Package: payload types and codes for the HTTP header block parser.
`default_nettype none

package hhbp_pkg;

    // Byte roles reported with each result beat
    localparam logic [2:0] ROLE_BLANK   = 3'd0;
    localparam logic [2:0] ROLE_KEY     = 3'd1;
    localparam logic [2:0] ROLE_COLON   = 3'd2;
    localparam logic [2:0] ROLE_SPACE   = 3'd3;
    localparam logic [2:0] ROLE_VALUE   = 3'd4;
    localparam logic [2:0] ROLE_EOL     = 3'd5;
    localparam logic [2:0] ROLE_BODY    = 3'd6;
    localparam logic [2:0] ROLE_IGNORED = 3'd7;

    // Sticky error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_KEY_BREAK = 3'd1;
    localparam logic [2:0] ERR_NO_SPACE  = 3'd2;
    localparam logic [2:0] ERR_VAL_LONG  = 3'd3;
    localparam logic [2:0] ERR_CR_NO_LF  = 3'd4;
    localparam logic [2:0] ERR_EMPTY     = 3'd5;

    // Characters
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    localparam logic [9:0] VALUE_LIMIT_RST = 10'd255;

    typedef struct packed {
        logic       restart;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [7:0]  byte_echo;
        logic [2:0]  byte_role;
        logic        field_done;
        logic [7:0]  key_length;
        logic [10:0] value_length;
        logic        headers_done;
        logic        error_flag;
        logic [2:0]  error_code;
    } t_out;

endpackage

`default_nettype wire

// ----- hw/rtl/hhbp_core.sv -----
// Header field state machine: parse state, counters, sticky error and per-byte result.
`default_nettype none

module hhbp_core #(
    parameter int KEY_LEN_MAX = 255
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_adv,
    input  wire hhbp_pkg::t_in i_item,
    input  wire logic [9:0]    i_value_limit,
    output hhbp_pkg::t_out     o_res
);
    import hhbp_pkg::*;

    localparam logic [7:0] KeyCap = 8'((KEY_LEN_MAX > 255) ? 255 : KEY_LEN_MAX);

    typedef enum logic [3:0] {
        ST_START, ST_KEY, ST_COLON, ST_SPACE, ST_VALUE,
        ST_CR, ST_LF, ST_END_CR, ST_END_LF
    } t_state;

    t_state      r_state, n_state, cur_state;
    logic [7:0]  r_key_cnt, n_key_cnt, cur_key_cnt;
    logic [10:0] r_val_cnt, n_val_cnt, cur_val_cnt;
    logic [2:0]  r_err, n_err, cur_err;

    logic [7:0]  b;
    logic [2:0]  role;
    logic [2:0]  err;
    logic        fdone;
    logic        hdone;

    // Restart clears everything before the byte is handled
    always_comb begin
        if (i_item.restart) begin
            cur_state   = ST_START;
            cur_key_cnt = '0;
            cur_val_cnt = '0;
            cur_err     = ERR_NONE;
        end else begin
            cur_state   = r_state;
            cur_key_cnt = r_key_cnt;
            cur_val_cnt = r_val_cnt;
            cur_err     = r_err;
        end
    end

    // One step of the header field machine
    always_comb begin
        b         = i_item.data_byte;
        role      = ROLE_IGNORED;
        err       = ERR_NONE;
        fdone     = 1'b0;
        hdone     = 1'b0;
        n_state   = cur_state;
        n_key_cnt = cur_key_cnt;
        n_val_cnt = cur_val_cnt;
        n_err     = cur_err;
        if (cur_err == ERR_NONE) begin
            unique case (cur_state)
                ST_KEY: begin
                    if (b == CH_COLON) begin
                        if (cur_key_cnt == '0) begin
                            err = ERR_EMPTY;
                        end else begin
                            role    = ROLE_COLON;
                            n_state = ST_COLON;
                        end
                    end else if (b == CH_CR || b == CH_LF) begin
                        err = ERR_KEY_BREAK;
                    end else begin
                        role = ROLE_KEY;
                        if (cur_key_cnt < KeyCap) n_key_cnt = cur_key_cnt + 8'd1;
                    end
                end
                ST_COLON: begin
                    if (b == CH_SPACE) begin
                        role    = ROLE_SPACE;
                        n_state = ST_SPACE;
                    end else begin
                        err = ERR_NO_SPACE;
                    end
                end
                ST_SPACE: begin
                    role      = ROLE_VALUE;
                    n_val_cnt = 11'd1;
                    n_state   = ST_VALUE;
                end
                ST_VALUE: begin
                    if (b == CH_CR) begin
                        if (cur_val_cnt == '0) begin
                            err = ERR_EMPTY;
                        end else begin
                            role    = ROLE_EOL;
                            n_state = ST_CR;
                        end
                    end else if (cur_val_cnt > {1'b0, i_value_limit}) begin
                        err = ERR_VAL_LONG;
                    end else begin
                        role      = ROLE_VALUE;
                        n_val_cnt = cur_val_cnt + 11'd1;
                    end
                end
                ST_CR: begin
                    if (b == CH_LF) begin
                        role    = ROLE_EOL;
                        fdone   = 1'b1;
                        n_state = ST_LF;
                    end else begin
                        err = ERR_CR_NO_LF;
                    end
                end
                ST_LF: begin
                    if (b == CH_CR) begin
                        role    = ROLE_EOL;
                        n_state = ST_END_CR;
                    end else begin
                        role      = ROLE_KEY;
                        n_key_cnt = 8'd1;
                        n_val_cnt = '0;
                        n_state   = ST_KEY;
                    end
                end
                ST_END_CR: begin
                    if (b == CH_LF) begin
                        role    = ROLE_EOL;
                        hdone   = 1'b1;
                        n_state = ST_END_LF;
                    end else begin
                        err = ERR_CR_NO_LF;
                    end
                end
                ST_END_LF: begin
                    role = ROLE_BODY;
                end
                default: begin
                    // line start: skip blank line ends, anything else opens a key
                    if (b == CH_CR || b == CH_LF) begin
                        role = ROLE_BLANK;
                    end else begin
                        role      = ROLE_KEY;
                        n_key_cnt = 8'd1;
                        n_val_cnt = '0;
                        n_state   = ST_KEY;
                    end
                end
            endcase
            if (err != ERR_NONE) begin
                n_err     = err;
                role      = ROLE_IGNORED;
                n_state   = cur_state;
                n_key_cnt = cur_key_cnt;
                n_val_cnt = cur_val_cnt;
            end
        end
    end

    // Result for this byte
    always_comb begin
        o_res.byte_echo    = b;
        o_res.byte_role    = role;
        o_res.field_done   = fdone;
        o_res.key_length   = fdone ? cur_key_cnt : 8'd0;
        o_res.value_length = fdone ? cur_val_cnt : 11'd0;
        o_res.headers_done = hdone;
        o_res.error_flag   = (n_err != ERR_NONE);
        o_res.error_code   = n_err;
    end

    // Parser state, advanced once per byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_START;
            r_key_cnt <= '0;
            r_val_cnt <= '0;
            r_err     <= ERR_NONE;
        end else if (i_adv) begin
            r_state   <= n_state;
            r_key_cnt <= n_key_cnt;
            r_val_cnt <= n_val_cnt;
            r_err     <= n_err;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/http_header_block_parser_top.sv -----
// Top level: input register, header field parser core, result register, config register.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in) carries one header stream
//   byte per beat, with a restart flag that returns the parser to line start
//   and clears a held error before that byte is parsed.
//   Output channel (o_out_valid / i_out_ready / o_out) returns exactly one
//   result beat per input beat: the byte, its role, field and header-block
//   end markers with key/value lengths, and the sticky error status.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) writes the value
//   length limit; it is always ready and should be written while idle.
// Timing:
//   A beat passes the input register, then the parser logic into the result
//   register. Throughput is one byte per cycle while the receiver keeps
//   i_out_ready high, set by the state update in the parser core.
// Reset: parser at line start, counters and error cleared, limit 255, both
//   pipeline registers empty.
// Stall: when the receiver holds i_out_ready low, the result register holds,
//   the input register fills, and o_in_ready drops until a beat drains.
`default_nettype none

module http_header_block_parser_top #(
    parameter int KEY_LEN_MAX = 255
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire hhbp_pkg::t_in  i_in,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output hhbp_pkg::t_out      o_out,
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic [9:0]     i_cfg_data
);
    import hhbp_pkg::*;

    logic       r_in_valid;
    t_in        r_in;
    logic       r_out_valid;
    t_out       r_out;
    logic [9:0] r_value_limit;
    logic       adv;
    t_out       res;

    // Pipeline control: byte moves into the result register when it has room
    assign adv         = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || adv;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    hhbp_core #(
        .KEY_LEN_MAX(KEY_LEN_MAX)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_item       (r_in),
        .i_value_limit(r_value_limit),
        .o_res        (res)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= res;
        end
    end

    // Value length limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value_limit <= VALUE_LIMIT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_value_limit <= i_cfg_data;
        end
    end

endmodule

`default_nettype wire

// ----- verif/http_header_block_parser_top_test.sv -----
// Self-checking testbench for the HTTP header block parser: byte stream stimulus and checks.
module http_header_block_parser_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import hhbp_pkg::*;

    localparam int KEY_LEN_MAX = 255;
    localparam int KEY_CAP     = (KEY_LEN_MAX > 255) ? 255 : KEY_LEN_MAX;

    // Header field machine states, local to the checker
    typedef enum logic [3:0] {
        PS_START, PS_KEY, PS_COLON, PS_SPACE, PS_VALUE, PS_CR, PS_LF, PS_END_CR, PS_END_LF
    } t_parse_state;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    t_in        in_item   = '0;
    logic       out_ready = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [9:0] cfg_data  = '0;
    logic       in_ready;
    logic       out_valid;
    t_out       out_item;
    logic       cfg_ready;

    // Checker copy of the parser state and the limit register
    t_parse_state parse_st        = PS_START;
    logic [7:0]   key_cnt         = '0;
    logic [10:0]  val_cnt         = '0;
    logic [2:0]   held_err        = ERR_NONE;
    logic [9:0]   value_limit_cfg = VALUE_LIMIT_RST;

    t_in  stream_bytes[$];
    t_out header_results_due[$];
    int unsigned mismatch_count = 0;

    // Sender burst and gap counters
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    // Receiver stall pattern
    int unsigned stall_mode   = 0;
    int unsigned mode_left    = 0;
    int unsigned hold_left    = 0;
    int unsigned hold_backoff = 0;

    http_header_block_parser_top #(
        .KEY_LEN_MAX(KEY_LEN_MAX)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in       (in_item),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out      (out_item),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Expected result of one header byte; advances the checker state
    function automatic t_out parse_header_byte(t_in item);
        t_out       res;
        logic [2:0] err;
        logic [7:0] b;
        res           = '0;
        err           = ERR_NONE;
        b             = item.data_byte;
        res.byte_echo = b;
        res.byte_role = ROLE_IGNORED;
        if (item.restart) begin
            parse_st = PS_START;
            key_cnt  = '0;
            val_cnt  = '0;
            held_err = ERR_NONE;
        end
        if (held_err == ERR_NONE) begin
            case (parse_st)
                PS_KEY: begin
                    if (b == CH_COLON) begin
                        if (key_cnt == 0) err = ERR_EMPTY;
                        else begin
                            res.byte_role = ROLE_COLON;
                            parse_st      = PS_COLON;
                        end
                    end else if (b == CH_CR || b == CH_LF) begin
                        err = ERR_KEY_BREAK;
                    end else begin
                        res.byte_role = ROLE_KEY;
                        if (key_cnt < KEY_CAP) key_cnt = key_cnt + 8'd1;
                    end
                end
                PS_COLON: begin
                    if (b == CH_SPACE) begin
                        res.byte_role = ROLE_SPACE;
                        parse_st      = PS_SPACE;
                    end else begin
                        err = ERR_NO_SPACE;
                    end
                end
                // first value byte is taken whatever it is
                PS_SPACE: begin
                    res.byte_role = ROLE_VALUE;
                    val_cnt       = 11'd1;
                    parse_st      = PS_VALUE;
                end
                PS_VALUE: begin
                    if (b == CH_CR) begin
                        if (val_cnt == 0) err = ERR_EMPTY;
                        else begin
                            res.byte_role = ROLE_EOL;
                            parse_st      = PS_CR;
                        end
                    end else if (val_cnt > value_limit_cfg) begin
                        err = ERR_VAL_LONG;
                    end else begin
                        res.byte_role = ROLE_VALUE;
                        val_cnt       = val_cnt + 11'd1;
                    end
                end
                PS_CR: begin
                    if (b == CH_LF) begin
                        res.byte_role    = ROLE_EOL;
                        res.field_done   = 1'b1;
                        res.key_length   = key_cnt;
                        res.value_length = val_cnt;
                        parse_st         = PS_LF;
                    end else begin
                        err = ERR_CR_NO_LF;
                    end
                end
                PS_LF: begin
                    if (b == CH_CR) begin
                        res.byte_role = ROLE_EOL;
                        parse_st      = PS_END_CR;
                    end else begin
                        res.byte_role = ROLE_KEY;
                        key_cnt       = 8'd1;
                        val_cnt       = '0;
                        parse_st      = PS_KEY;
                    end
                end
                PS_END_CR: begin
                    if (b == CH_LF) begin
                        res.byte_role    = ROLE_EOL;
                        res.headers_done = 1'b1;
                        parse_st         = PS_END_LF;
                    end else begin
                        err = ERR_CR_NO_LF;
                    end
                end
                PS_END_LF: res.byte_role = ROLE_BODY;
                default: begin
                    if (b == CH_CR || b == CH_LF) begin
                        res.byte_role = ROLE_BLANK;
                    end else begin
                        res.byte_role = ROLE_KEY;
                        key_cnt       = 8'd1;
                        val_cnt       = '0;
                        parse_st      = PS_KEY;
                    end
                end
            endcase
            if (err != ERR_NONE) begin
                held_err      = err;
                res.byte_role = ROLE_IGNORED;
            end
        end
        res.error_flag = (held_err != ERR_NONE);
        res.error_code = held_err;
        return res;
    endfunction

    // Sender: bursts of beats with random gaps, fed from stream_bytes
    always @(posedge clk) begin : drive_bytes
        logic nxt_valid;
        t_in  nxt_item;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            nxt_valid = in_valid;
            nxt_item  = in_item;
            if (in_valid && in_ready) begin
                header_results_due.push_back(parse_header_byte(in_item));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (stream_bytes.size() > 0) begin
                    nxt_item  = stream_bytes.pop_front();
                    nxt_valid = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 48);
                        case ($urandom_range(0, 3))
                            0:       gap_left = 0;
                            3:       gap_left = $urandom_range(5, 20);
                            default: gap_left = $urandom_range(1, 4);
                        endcase
                    end
                end
            end
            in_valid <= nxt_valid;
            in_item  <= nxt_item;
        end
    end

    // Receiver: stall modes of random length, plus a long hold-off while input is queued
    always @(posedge clk) begin : drive_ready
        logic rdy;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (hold_backoff > 0) hold_backoff--;
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (hold_backoff == 0 && stream_bytes.size() > 100) begin
                hold_left    = 150;
                hold_backoff = 4000;
                rdy          = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left  = $urandom_range(5, 80);
                end else begin
                    mode_left--;
                end
                case (stall_mode)
                    0:       rdy = 1'b1;
                    1:       rdy = 1'($urandom_range(0, 1));
                    2:       rdy = ($urandom_range(0, 3) == 0);
                    default: rdy = ($urandom_range(0, 7) != 0);
                endcase
            end
            out_ready <= rdy;
        end
    end

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Monitor: compare each result beat with the oldest expectation
    always @(posedge clk) begin : check_results
        t_out want;
        if (rst_n && out_valid && out_ready) begin
            if (header_results_due.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result beat, expected none, actual byte %0d",
                         $time, out_item.byte_echo);
            end else begin
                want = header_results_due.pop_front();
                check_field("byte_echo", 32'(want.byte_echo), 32'(out_item.byte_echo));
                check_field("byte_role", 32'(want.byte_role), 32'(out_item.byte_role));
                check_field("field_done", 32'(want.field_done), 32'(out_item.field_done));
                check_field("key_length", 32'(want.key_length), 32'(out_item.key_length));
                check_field("value_length", 32'(want.value_length),
                            32'(out_item.value_length));
                check_field("headers_done", 32'(want.headers_done),
                            32'(out_item.headers_done));
                check_field("error_flag", 32'(want.error_flag), 32'(out_item.error_flag));
                check_field("error_code", 32'(want.error_code), 32'(out_item.error_code));
            end
        end
    end

    function automatic logic [7:0] rand_byte_avoiding(logic [7:0] x, logic [7:0] y, logic [7:0] z);
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == x || b == y || b == z);
        return b;
    endfunction

    // Random byte biased toward the characters the parser reacts to
    function automatic logic [7:0] pick_noise_byte();
        case ($urandom_range(0, 5))
            0:       return CH_CR;
            1:       return CH_LF;
            2:       return CH_COLON;
            3:       return CH_SPACE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_beat(logic rs, logic [7:0] b);
        stream_bytes.push_back('{restart: rs, data_byte: b});
    endtask

    // One header block with random content, sometimes broken or followed by noise
    task automatic queue_header_block(input logic [9:0] limit, input int unsigned long_mode,
                                      inout int unsigned queued);
        t_in         blk[$];
        int unsigned n_fields, key_len, val_len, cap, f;
        blk = {};
        cap = limit + 1;
        repeat ($urandom_range(0, 2))
            blk.push_back('{restart: 1'b0, data_byte: ($urandom_range(0, 1) ? CH_CR : CH_LF)});
        n_fields = $urandom_range(1, 4);
        for (f = 0; f < n_fields; f++) begin
            if (long_mode == 1 && f == 0) key_len = 300;
            else if ($urandom_range(0, 99) < 3) key_len = $urandom_range(250, 260);
            else key_len = $urandom_range(1, 8);
            // a later line may start its key with LF or a colon
            blk.push_back('{restart: 1'b0, data_byte: (f == 0) ?
                            rand_byte_avoiding(CH_CR, CH_LF, CH_CR) :
                            rand_byte_avoiding(CH_CR, CH_CR, CH_CR)});
            repeat (key_len - 1)
                blk.push_back('{restart: 1'b0,
                                data_byte: rand_byte_avoiding(CH_COLON, CH_CR, CH_LF)});
            blk.push_back('{restart: 1'b0, data_byte: CH_COLON});
            blk.push_back('{restart: 1'b0, data_byte: CH_SPACE});
            if (long_mode != 0 && f == 0) val_len = (long_mode == 1) ? cap : cap + 1;
            else if (cap <= 40 && $urandom_range(0, 9) < 2) val_len = cap + $urandom_range(0, 1);
            else val_len = $urandom_range(1, (cap < 10) ? cap : 10);
            blk.push_back('{restart: 1'b0, data_byte: pick_noise_byte()});
            repeat (val_len - 1)
                blk.push_back('{restart: 1'b0,
                                data_byte: rand_byte_avoiding(CH_CR, CH_CR, CH_CR)});
            blk.push_back('{restart: 1'b0, data_byte: CH_CR});
            blk.push_back('{restart: 1'b0, data_byte: CH_LF});
        end
        // empty line and a little body, mostly
        if ($urandom_range(0, 4) != 0) begin
            blk.push_back('{restart: 1'b0, data_byte: CH_CR});
            blk.push_back('{restart: 1'b0, data_byte: CH_LF});
            repeat ($urandom_range(0, 3))
                blk.push_back('{restart: 1'b0, data_byte: 8'($urandom_range(0, 255))});
        end
        blk[0].restart = ($urandom_range(0, 9) != 0);
        if (long_mode == 0 && $urandom_range(0, 4) == 0)
            blk[$urandom_range(0, blk.size() - 1)].data_byte = pick_noise_byte();
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(4, 12))
                blk.push_back('{restart: ($urandom_range(0, 7) == 0),
                                data_byte: pick_noise_byte()});
        foreach (blk[i]) stream_bytes.push_back(blk[i]);
        queued += blk.size();
    endtask

    // Block drained: nothing queued, nothing in flight, nothing outstanding
    task automatic wait_idle();
        @(negedge clk);
        while (stream_bytes.size() != 0 || in_valid || header_results_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_value_limit(logic [9:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid       <= 1'b0;
        value_limit_cfg = v;
    endtask

    task automatic run_phase(input logic [9:0] limit, input int unsigned budget,
                             input int unsigned long_mode);
        int unsigned queued;
        queued = 0;
        write_value_limit(limit);
        @(negedge clk);
        if (long_mode != 0) queue_header_block(limit, long_mode, queued);
        while (queued < budget) queue_header_block(limit, 0, queued);
        wait_idle();
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: blanks, extreme bytes, CR/LF as first value byte, field and block end
        push_beat(1'b1, CH_CR);
        push_beat(1'b0, 8'h00);
        push_beat(1'b0, 8'hFF);
        push_beat(1'b0, CH_COLON);
        push_beat(1'b0, CH_SPACE);
        push_beat(1'b0, CH_CR);
        push_beat(1'b0, CH_LF);
        push_beat(1'b0, CH_CR);
        push_beat(1'b0, CH_LF);
        // LF opening the next key
        push_beat(1'b0, CH_LF);
        push_beat(1'b0, CH_COLON);
        push_beat(1'b0, CH_SPACE);
        push_beat(1'b0, 8'h76);
        push_beat(1'b0, CH_CR);
        push_beat(1'b0, CH_LF);
        push_beat(1'b0, CH_CR);
        push_beat(1'b0, CH_LF);
        push_beat(1'b0, 8'hFF);
        // colon as first key byte, then break in key, then ignored byte
        push_beat(1'b1, CH_COLON);
        push_beat(1'b0, CH_CR);
        push_beat(1'b0, 8'h00);
        // missing space after colon
        push_beat(1'b1, 8'h61);
        push_beat(1'b0, CH_COLON);
        push_beat(1'b0, 8'h78);
        // CR not followed by LF
        push_beat(1'b1, 8'h61);
        push_beat(1'b0, CH_COLON);
        push_beat(1'b0, CH_SPACE);
        push_beat(1'b0, 8'h76);
        push_beat(1'b0, CH_CR);
        push_beat(1'b0, 8'h78);
        wait_idle();

        // Random header blocks across limit settings
        run_phase(10'd1, 250, 2);
        run_phase(10'd0, 150, 1);
        run_phase(10'd1023, 200, 1);
        run_phase(10'd1023, 60, 2);
        run_phase(10'($urandom_range(2, 60)), 300, 0);
        run_phase(10'd255, 300, 1);
        run_phase(10'($urandom_range(1, 1023)), 300, 0);

        repeat (6) @(negedge clk);
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
